>>> rtl/core/lfia_pkg.sv
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared types, codes and helpers for the lowest free ID allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

    localparam int WORD_W = 64;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_RET = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [1:0] REG_ID_BASE  = 2'd0;
    localparam logic [1:0] REG_ID_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GET_RD,
        ST_GET_CHK,
        ST_RET_RD,
        ST_RET_WR
    } lfia_state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic rd_word;
        logic rd_pos;
        logic next_word;
        logic grant;
        logic empty;
        logic bad_range;
        logic release_id;
    } lfia_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic in_range;
        logic hit;
        logic more;
    } lfia_stat_t;

    // binary search for the lowest set bit
    function automatic logic [5:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [5:0]        k;
        v = w;
        k = '0;
        for (int i = 5; i >= 0; i--)
        begin
            if ((v & ((64'd1 << (1 << i)) - 64'd1)) == 64'd0)
            begin
                v    = v >> (1 << i);
                k[i] = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

>>> rtl/core/lfia_ctrl.sv
// ----------------------------------------------------------------------------
// lfia_ctrl
// Sequencer: reset clear sweep, word-by-word scan for get, read-modify-write
// for return.
// ----------------------------------------------------------------------------
module lfia_ctrl
    import lfia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       kind,
    input  lfia_stat_t stat,
    output lfia_cmd_t  cmd,
    output logic       busy
);

    lfia_state_t state_reg;
    lfia_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = (kind == KIND_RET) ? ST_RET_RD : ST_GET_RD;
            end
            ST_GET_RD:
            begin
                state_next = ST_GET_CHK;
            end
            ST_GET_CHK:
            begin
                state_next = (stat.hit || !stat.more) ? ST_IDLE : ST_GET_RD;
            end
            ST_RET_RD:
            begin
                state_next = stat.in_range ? ST_RET_WR : ST_IDLE;
            end
            ST_RET_WR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_GET_RD:
            begin
                cmd.rd_word = 1'b1;
            end
            ST_GET_CHK:
            begin
                cmd.grant     = stat.hit;
                cmd.empty     = !stat.hit && !stat.more;
                cmd.next_word = !stat.hit && stat.more;
            end
            ST_RET_RD:
            begin
                cmd.rd_pos    = stat.in_range;
                cmd.bad_range = !stat.in_range;
            end
            ST_RET_WR:
            begin
                cmd.release_id = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.grant, cmd.empty, cmd.bad_range, cmd.release_id}))
        else $error("more than one result issued in a cycle");

    a_grant_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> $past(cmd.rd_word))
        else $error("grant without a fresh word read");

    a_release_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.release_id |-> $past(cmd.rd_pos))
        else $error("release without a word read");

endmodule

>>> rtl/core/lfia_dp.sv
// ----------------------------------------------------------------------------
// lfia_dp
// Free bitmap memory (64-bit words), config registers, range check, word
// masking, lowest bit search and result registers.
// ----------------------------------------------------------------------------
module lfia_dp
    import lfia_pkg::*;
#(
    parameter int ID_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lfia_cmd_t   cmd,
    output lfia_stat_t  stat,
    input  logic        kind,
    input  logic [16:0] id,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [16:0] granted_id
);

    localparam int WORDS  = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    logic [15:0]       base_reg;
    logic [8:0]        count_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] word_idx_reg;
    logic              kind_reg;
    logic [16:0]       id_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [16:0]       granted_reg;

    logic [8:0]        n_eff;
    logic [16:0]       pos;
    logic [ADDR_W-1:0] pos_word;
    logic [17:0]       lo;
    logic [17:0]       rem;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] masked;
    logic [5:0]        bit_pos;
    logic              lo_in;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    assign n_eff    = (32'(count_reg) > ID_COUNT) ? 9'(ID_COUNT) : count_reg;
    assign pos      = id_reg - {1'b0, base_reg};
    assign pos_word = pos[ADDR_W+5:6];
    assign lo       = 18'(word_idx_reg) << 6;
    assign rem      = 18'(n_eff) - lo;
    assign lo_in    = lo < 18'(n_eff);
    assign mask     = (rem < 18'(WORD_W)) ? ((64'd1 << rem[5:0]) - 64'd1) : '1;
    assign masked   = rd_data_reg & mask;
    assign bit_pos  = lowest_bit(masked);

    assign stat.clear_done = (clr_addr_reg == LAST_WORD);
    assign stat.in_range   = (id_reg >= {1'b0, base_reg}) && (pos < 17'(n_eff));
    assign stat.hit        = lo_in && (masked != '0);
    assign stat.more       = (word_idx_reg != LAST_WORD) && (lo + 18'(WORD_W) < 18'(n_eff));

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = word_idx_reg;
        mem_wd = rd_data_reg & ~(64'd1 << bit_pos);
        mem_re = cmd.rd_word || cmd.rd_pos;
        mem_ra = cmd.rd_pos ? pos_word : word_idx_reg;
        priority if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '1;
        end
        else if (cmd.grant)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.release_id)
        begin
            mem_we = 1'b1;
            mem_wa = pos_word;
            mem_wd = rd_data_reg | (64'd1 << pos[5:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            count_reg    <= 9'd256;
            clr_addr_reg <= '0;
            word_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_ID_BASE)
                base_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_ID_COUNT)
                count_reg <= cfg_data[8:0];
            if (cmd.clear_wr && !stat.clear_done)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (cmd.load)
                word_idx_reg <= '0;
            else if (cmd.next_word)
                word_idx_reg <= word_idx_reg + ADDR_W'(1);
            done_reg <= cmd.grant || cmd.empty || cmd.bad_range || cmd.release_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            id_reg   <= id;
        end
        if (cmd.grant)
            granted_reg <= 17'(base_reg) + 17'(lo) + 17'(bit_pos);
        else
            granted_reg <= '0;
        if (cmd.empty)
            status_reg <= STATUS_EMPTY;
        else if (cmd.bad_range)
            status_reg <= STATUS_RANGE;
        else
            status_reg <= STATUS_OK;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg == STATUS_OK || status_reg == STATUS_EMPTY ||
                      status_reg == STATUS_RANGE))
        else $error("undefined status code");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != STATUS_OK |-> granted_reg == '0)
        else $error("nonzero id with failing status");

    a_return_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_pos || cmd.bad_range |-> kind_reg == KIND_RET)
        else $error("return path entered for a get");

endmodule

>>> rtl/core/lowest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// ID pool over a free bitmap: get hands out the lowest free ID, return
// frees one; out-of-pool returns are flagged.
//
//   channel   signals                         handshake
//   request   kind, id                        start & !busy
//   result    status, granted_id              done, one cycle, no stall
//   config    cfg_index, cfg_data             cfg_we
//
// Get: busy in a read and a check state per 64-bit bitmap word scanned,
//   until a hit or the end of the pool; the result is registered.
// Return: busy for a read and a write back, only the read when the id is
//   outside the pool; the result is registered.
// After reset a clear pass fills the bitmap word by word, with busy high.
// done is a single-cycle strobe; results cannot be held off.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator
    import lfia_pkg::*;
#(
    parameter int ID_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [16:0] id,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [16:0] granted_id
);

    lfia_cmd_t  cmd;
    lfia_stat_t stat;

    lfia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    lfia_dp #(
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .id         (id),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .granted_id (granted_id)
    );

endmodule
